/* rtl/core/ptd_pkg.sv */
`timescale 1ns / 1ps

package ptd_pkg;

    // Operation codes carried on the request channel
    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_CREATE   = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_COMPLETE = 2'd3
    } t_op;

    // Completion codes carried on the response channel
    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_FULL        = 3'd1,
        STAT_NO_TASK     = 3'd2,
        STAT_NONE_READY  = 3'd3,
        STAT_NOT_RUNNING = 3'd4
    } t_status;

    // Per-slot run state
    typedef enum logic [1:0] {
        SLOT_SUSPENDED = 2'd0,
        SLOT_READY     = 2'd1,
        SLOT_RUNNING   = 2'd2
    } t_slot_state;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } t_state;

    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned SLOT_W   = 4;

    // One row of the slot table
    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TICK_W-1:0]   last_run;
        t_slot_state         state;
    } t_slot_entry;

endpackage

/* rtl/core/ptd_if.sv */
`timescale 1ns / 1ps

// Request channel
interface ptd_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [15:0]                 period;
    logic                        task_present;
    logic [3:0]                  slot;

    modport source (output valid, output op, output period, output task_present,
                    output slot, input ready);
    modport sink   (input valid, input op, input period, input task_present,
                    input slot, output ready);
endinterface

// Response channel
interface ptd_out_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  status;
    logic [3:0]                  granted_slot;
    logic [31:0]                 tick_now;

    modport source (output valid, output status, output granted_slot,
                    output tick_now, input ready);
    modport sink   (input valid, input status, input granted_slot,
                    input tick_now, output ready);
endinterface

/* rtl/core/ptd_slot_mem.sv */
`timescale 1ns / 1ps

module ptd_slot_mem #(
    parameter int unsigned IW = 4
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [IW-1:0]        i_waddr,
    input  ptd_pkg::t_slot_entry i_wdata,
    input  logic [IW-1:0]        i_raddr,
    output ptd_pkg::t_slot_entry o_rdata
);

    ptd_pkg::t_slot_entry r_mem [0:(1 << IW)-1];
    ptd_pkg::t_slot_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/ptd_due_unit.sv */
`timescale 1ns / 1ps

// Deadline check: due when tick >= period + last_run, sum taken modulo 2^32, unsigned compare
module ptd_due_unit (
    input  logic [ptd_pkg::PERIOD_W-1:0] i_period,
    input  logic [ptd_pkg::TICK_W-1:0]   i_last_run,
    input  logic [ptd_pkg::TICK_W-1:0]   i_tick,
    output logic                         o_due
);

    logic [ptd_pkg::TICK_W-1:0] deadline;

    assign deadline = ptd_pkg::TICK_W'(i_period) + i_last_run;
    assign o_due    = (i_tick >= deadline);

endmodule

/* rtl/core/ptd_core.sv */
`timescale 1ns / 1ps

module ptd_core #(
    parameter int unsigned MAX_SLOTS = 16,
    parameter int unsigned IW        = 4,
    parameter int unsigned CW        = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ptd_in_if.sink                         i_in,
    ptd_out_if.source                      o_out,
    output logic                           o_mem_we,
    output logic [IW-1:0]                  o_mem_waddr,
    output ptd_pkg::t_slot_entry           o_mem_wdata,
    output logic [IW-1:0]                  o_mem_raddr,
    input  ptd_pkg::t_slot_entry           i_mem_rdata,
    output logic [ptd_pkg::PERIOD_W-1:0]   o_due_period,
    output logic [ptd_pkg::TICK_W-1:0]     o_due_last_run,
    output logic [ptd_pkg::TICK_W-1:0]     o_due_tick,
    input  logic                           i_due
);

    ptd_pkg::t_state  r_state, n_state;
    ptd_pkg::t_op     r_op, n_op;
    ptd_pkg::t_status r_status, n_status;
    logic [IW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_count, n_count;
    logic [31:0]      r_tick, n_tick;
    logic [3:0]       r_grant, n_grant;
    logic             r_found, n_found;

    logic             r_out_valid, n_out_valid;
    ptd_pkg::t_status r_out_status, n_out_status;
    logic [3:0]       r_out_grant, n_out_grant;
    logic [31:0]      r_out_tick, n_out_tick;

    logic             accept;
    logic             out_free;
    logic             table_full;
    logic             slot_in_use;
    logic             last_idx;
    logic [31:0]      slot_ext;
    logic [31:0]      count_ext;
    ptd_pkg::t_slot_state new_state;

    assign accept      = i_in.valid && (r_state == ptd_pkg::S_IDLE);
    assign out_free    = !r_out_valid || o_out.ready;
    assign table_full  = (32'(r_count) >= MAX_SLOTS);
    assign slot_ext    = 32'(i_in.slot);
    assign count_ext   = 32'(r_count);
    assign slot_in_use = (slot_ext < count_ext) && (slot_ext < MAX_SLOTS);
    assign last_idx    = ((32'(r_idx) + 32'd1) == count_ext);

    assign i_in.ready         = (r_state == ptd_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.granted_slot = r_out_grant;
    assign o_out.tick_now     = r_out_tick;

    assign o_due_period   = i_mem_rdata.period;
    assign o_due_last_run = i_mem_rdata.last_run;
    assign o_due_tick     = r_tick;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ptd_pkg::S_IDLE: begin
                if (accept) begin
                    case (ptd_pkg::t_op'(i_in.op))
                        ptd_pkg::OP_TICK, ptd_pkg::OP_DISPATCH: begin
                            n_state = (r_count == '0) ? ptd_pkg::S_DONE : ptd_pkg::S_EVAL;
                        end
                        ptd_pkg::OP_COMPLETE: begin
                            n_state = slot_in_use ? ptd_pkg::S_EVAL : ptd_pkg::S_DONE;
                        end
                        default: begin
                            n_state = ptd_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ptd_pkg::S_EVAL: begin
                if (r_op == ptd_pkg::OP_COMPLETE || last_idx) begin
                    n_state = ptd_pkg::S_DONE;
                end
            end
            ptd_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = ptd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ptd_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb begin
        n_op         = r_op;
        n_status     = r_status;
        n_idx        = r_idx;
        n_count      = r_count;
        n_tick       = r_tick;
        n_grant      = r_grant;
        n_found      = r_found;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_grant  = r_out_grant;
        n_out_tick   = r_out_tick;
        o_mem_we     = 1'b0;
        o_mem_waddr  = r_idx;
        o_mem_wdata  = i_mem_rdata;
        o_mem_raddr  = IW'(32'(r_idx) + 32'd1);
        new_state    = i_mem_rdata.state;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ptd_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = ptd_pkg::t_op'(i_in.op);
                    n_status = ptd_pkg::STAT_OK;
                    n_grant  = '0;
                    n_found  = 1'b0;
                    n_idx    = '0;
                    o_mem_raddr = '0;
                    case (ptd_pkg::t_op'(i_in.op))
                        ptd_pkg::OP_TICK: begin
                            n_tick = r_tick + 32'd1;
                        end
                        ptd_pkg::OP_CREATE: begin
                            if (table_full) begin
                                n_status = ptd_pkg::STAT_FULL;
                            end else if (!i_in.task_present) begin
                                n_status = ptd_pkg::STAT_NO_TASK;
                            end else begin
                                // Append the slot, ready at once
                                o_mem_we             = 1'b1;
                                o_mem_waddr          = r_count[IW-1:0];
                                o_mem_wdata.period   = i_in.period;
                                o_mem_wdata.last_run = r_tick;
                                o_mem_wdata.state    = ptd_pkg::SLOT_READY;
                                n_count              = r_count + CW'(1);
                                n_grant              = count_ext[3:0];
                            end
                        end
                        ptd_pkg::OP_DISPATCH: begin
                            n_status = ptd_pkg::STAT_NONE_READY;
                        end
                        default: begin
                            o_mem_raddr = slot_ext[IW-1:0];
                            n_idx       = slot_ext[IW-1:0];
                            if (!slot_in_use) begin
                                n_status = ptd_pkg::STAT_NOT_RUNNING;
                            end
                        end
                    endcase
                end
            end
            ptd_pkg::S_EVAL: begin
                o_mem_we = 1'b1;
                if (r_op == ptd_pkg::OP_COMPLETE) begin
                    if (i_mem_rdata.state == ptd_pkg::SLOT_RUNNING) begin
                        o_mem_wdata.state    = ptd_pkg::SLOT_SUSPENDED;
                        o_mem_wdata.last_run = r_tick;
                    end else begin
                        o_mem_we = 1'b0;
                        n_status = ptd_pkg::STAT_NOT_RUNNING;
                    end
                end else begin
                    // Wake a due suspended slot, then on dispatch grant the first ready one
                    if (i_mem_rdata.state == ptd_pkg::SLOT_SUSPENDED && i_due) begin
                        new_state = ptd_pkg::SLOT_READY;
                    end
                    if (r_op == ptd_pkg::OP_DISPATCH && !r_found &&
                        new_state == ptd_pkg::SLOT_READY) begin
                        new_state = ptd_pkg::SLOT_RUNNING;
                        n_found   = 1'b1;
                        n_status  = ptd_pkg::STAT_OK;
                        n_grant   = 4'(r_idx);
                    end
                    o_mem_wdata.state = new_state;
                    n_idx = IW'(32'(r_idx) + 32'd1);
                end
            end
            ptd_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_grant  = r_grant;
                    n_out_tick   = r_tick;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptd_pkg::S_IDLE;
            r_count     <= '0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_idx        <= n_idx;
        r_grant      <= n_grant;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_grant  <= n_out_grant;
        r_out_tick   <= n_out_tick;
    end

endmodule

/* rtl/core/periodic_task_dispatcher.sv */
`timescale 1ns / 1ps

// Periodic task dispatcher: holds up to MAX_SLOTS periodic task slots in a
// single-port-read table plus a 32-bit tick counter that each tick request
// advances, and answers every request transaction with exactly one response
// transaction. Create writes any new slot at accept and then loads the
// response; complete does one table read, then one check and write-back; tick
// and dispatch walk every slot in use through one shared deadline
// adder/comparator, one slot per cycle, and skip the walk with an empty
// table. The walk is set by the table's single read port and the one deadline
// unit. The request side is ready only while the sequencer is idle; a
// finished response sits in an output register, so a new request is taken
// while the previous response still waits for the sink.
// Slot order is a fixed priority: dispatch grants the lowest-numbered ready
// slot after waking every suspended slot whose deadline has passed.
module periodic_task_dispatcher #(
    parameter int unsigned MAX_SLOTS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ptd_in_if.sink     i_in,
    ptd_out_if.source  o_out
);

    localparam int unsigned IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CW = $clog2(MAX_SLOTS + 1);

    logic                         mem_we;
    logic [IW-1:0]                mem_waddr;
    ptd_pkg::t_slot_entry         mem_wdata;
    logic [IW-1:0]                mem_raddr;
    ptd_pkg::t_slot_entry         mem_rdata;
    logic [ptd_pkg::PERIOD_W-1:0] due_period;
    logic [ptd_pkg::TICK_W-1:0]   due_last_run;
    logic [ptd_pkg::TICK_W-1:0]   due_tick;
    logic                         due;

    // Slot table: period, last completion tick and run state per slot
    ptd_slot_mem #(
        .IW (IW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Shared deadline check, reused for every slot of a walk
    ptd_due_unit u_due_unit (
        .i_period   (due_period),
        .i_last_run (due_last_run),
        .i_tick     (due_tick),
        .o_due      (due)
    );

    // Sequencer, counters and response register
    ptd_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .IW        (IW),
        .CW        (CW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .o_out          (o_out),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_due_period   (due_period),
        .o_due_last_run (due_last_run),
        .o_due_tick     (due_tick),
        .i_due          (due)
    );

`ifndef SYNTHESIS
    // A failed request never carries a slot number
    a_err_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ptd_pkg::STAT_OK) |-> (o_out.granted_slot == 4'd0))
        else $error("error response carries a nonzero slot");

    // After an accept, the request side is not ready in the cycle that follows
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request side ready right after an accept");

    // Reset leaves no stale response
    a_reset_clears_out: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("response valid right after reset");
`endif

endmodule

/* test/ptd_checker.sv */
`timescale 1ns / 1ps

module ptd_checker
    import ptd_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ptd_in_if    i_req,
    ptd_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   granted_slot;
        logic [TICK_W-1:0]   tick_now;
    } t_sched_rsp;

    // Shadow copy of the slot table and tick counter
    logic [TICK_W-1:0]   tick_cnt;
    int unsigned         slots_used;
    logic [PERIOD_W-1:0] slot_period_q [MAX_SLOTS];
    logic [TICK_W-1:0]   slot_last_q   [MAX_SLOTS];
    t_slot_state         slot_state_q  [MAX_SLOTS];

    t_sched_rsp awaited_rsp [$];
    int         fail_tally;

    // Deadline sum wraps modulo 2^32; the compare is unsigned
    function automatic logic slot_is_due(int unsigned idx);
        logic [TICK_W-1:0] deadline;
        deadline = TICK_W'(slot_period_q[idx]) + slot_last_q[idx];
        return tick_cnt >= deadline;
    endfunction

    function automatic void wake_due_slots();
        for (int unsigned i = 0; i < slots_used && i < MAX_SLOTS; i++) begin
            if (slot_state_q[i] == SLOT_SUSPENDED && slot_is_due(i)) begin
                slot_state_q[i] = SLOT_READY;
            end
        end
    endfunction

    function automatic t_sched_rsp step_scheduler(t_op op, logic [PERIOD_W-1:0] period,
                                                  logic present, logic [SLOT_W-1:0] slot);
        t_sched_rsp rsp;
        rsp.status       = STAT_OK;
        rsp.granted_slot = '0;
        case (op)
            OP_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                wake_due_slots();
            end
            OP_CREATE: begin
                if (slots_used >= MAX_SLOTS) begin
                    rsp.status = STAT_FULL;
                end else if (!present) begin
                    rsp.status = STAT_NO_TASK;
                end else begin
                    slot_period_q[slots_used] = period;
                    slot_last_q[slots_used]   = tick_cnt;
                    slot_state_q[slots_used]  = SLOT_READY;
                    rsp.granted_slot          = SLOT_W'(slots_used);
                    slots_used                = slots_used + 1;
                end
            end
            OP_DISPATCH: begin
                wake_due_slots();
                rsp.status = STAT_NONE_READY;
                for (int unsigned i = 0; i < slots_used && i < MAX_SLOTS; i++) begin
                    if (slot_state_q[i] == SLOT_READY) begin
                        slot_state_q[i]  = SLOT_RUNNING;
                        rsp.status       = STAT_OK;
                        rsp.granted_slot = SLOT_W'(i);
                        break;
                    end
                end
            end
            default: begin
                if (slot < slots_used && slot < MAX_SLOTS
                        && slot_state_q[slot] == SLOT_RUNNING) begin
                    slot_state_q[slot] = SLOT_SUSPENDED;
                    slot_last_q[slot]  = tick_cnt;
                end else begin
                    rsp.status = STAT_NOT_RUNNING;
                end
            end
        endcase
        rsp.tick_now = tick_cnt;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_sched_rsp exp_rsp;
        if (!i_rst_n) begin
            tick_cnt   = '0;
            slots_used = 0;
            for (int unsigned i = 0; i < MAX_SLOTS; i++) begin
                slot_period_q[i] = '0;
                slot_last_q[i]   = '0;
                slot_state_q[i]  = SLOT_SUSPENDED;
            end
            awaited_rsp.delete();
            fail_tally = 0;
        end else begin
            // Retire the oldest expectation before queuing a new one
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_rsp.size() == 0) begin
                    $error("response with no request outstanding: status %0d slot %0d tick %0d",
                           i_rsp.status, i_rsp.granted_slot, i_rsp.tick_now);
                    fail_tally++;
                end else begin
                    exp_rsp = awaited_rsp.pop_front();
                    if (i_rsp.status !== exp_rsp.status) begin
                        $error("status: expected %0d, actual %0d", exp_rsp.status, i_rsp.status);
                        fail_tally++;
                    end
                    if (i_rsp.granted_slot !== exp_rsp.granted_slot) begin
                        $error("granted_slot: expected %0d, actual %0d",
                               exp_rsp.granted_slot, i_rsp.granted_slot);
                        fail_tally++;
                    end
                    if (i_rsp.tick_now !== exp_rsp.tick_now) begin
                        $error("tick_now: expected %0d, actual %0d",
                               exp_rsp.tick_now, i_rsp.tick_now);
                        fail_tally++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_rsp.push_back(step_scheduler(t_op'(i_req.op), i_req.period,
                                                     i_req.task_present, i_req.slot));
            end
        end
        o_pending    <= awaited_rsp.size();
        o_fail_count <= fail_tally;
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

// Dispatcher testbench: drives request transactions through a directed
// opening and four randomized phases, lets the response sink stall
// at random, and leaves all prediction and comparison to ptd_checker.
module tb_top;
    import ptd_pkg::*;

    localparam int unsigned SLOT_CAP  = 16;
    localparam int          RUN_LIMIT = 400000;
    localparam int          PHASE_LEN = 232;
    localparam int          TAIL_WAIT = 40;

    logic i_clk;
    logic i_rst_n;

    ptd_in_if  req_ch ();
    ptd_out_if rsp_ch ();

    int fail_count;
    int pending_count;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    periodic_task_dispatcher #(.MAX_SLOTS(SLOT_CAP)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    ptd_checker #(.MAX_SLOTS(SLOT_CAP)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Bound the run; a hung handshake ends here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Response sink: stall at the rate the current phase asks for
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Offer one request transaction, optionally after random idle cycles,
    // and hold it until the dispatcher takes it.
    task automatic send_req(input t_op op, input logic [15:0] period,
                            input logic present, input logic [3:0] slot);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.op           <= op;
        req_ch.period       <= period;
        req_ch.task_present <= present;
        req_ch.slot         <= slot;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Hold the request side quiet until every response has come back.
    // Waiting on the clock before polling lets the checker's count catch the last accept.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        int unsigned pick;
        int unsigned spread;
        logic [15:0] per;

        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.op           = OP_TICK;
        req_ch.period       = '0;
        req_ch.task_present = 1'b0;
        req_ch.slot         = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening, no idling.
        // Empty table: dispatch finds nothing, complete is refused, tick runs alone.
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        send_req(OP_COMPLETE, 16'hFFFF, 1'b1, 4'd0);
        send_req(OP_TICK,     16'h0000, 1'b0, 4'd0);
        // Create with no task, then the period extremes and a short period
        send_req(OP_CREATE,   16'h1234, 1'b0, 4'd0);
        send_req(OP_CREATE,   16'h0000, 1'b1, 4'd15);
        send_req(OP_CREATE,   16'hFFFF, 1'b1, 4'd0);
        send_req(OP_CREATE,   16'd3,    1'b1, 4'd0);
        // Grant every fresh slot in order, then run dry with all running
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        // Complete a slot out of range, then a good one twice
        send_req(OP_COMPLETE, 16'h0000, 1'b0, 4'd15);
        send_req(OP_COMPLETE, 16'h0000, 1'b0, 4'd1);
        send_req(OP_COMPLETE, 16'h0000, 1'b0, 4'd1);
        // Zero period wakes on the next tick; the huge period does not
        send_req(OP_COMPLETE, 16'h0000, 1'b0, 4'd0);
        send_req(OP_TICK,     16'hFFFF, 1'b1, 4'd15);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        // Short period wakes after three ticks while slot 0 still runs
        send_req(OP_COMPLETE, 16'h0000, 1'b0, 4'd2);
        send_req(OP_TICK,     16'h0000, 1'b0, 4'd0);
        send_req(OP_TICK,     16'h0000, 1'b0, 4'd0);
        send_req(OP_TICK,     16'h0000, 1'b0, 4'd0);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        send_req(OP_DISPATCH, 16'h0000, 1'b0, 4'd0);
        drain_responses();

        // Random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                per  = 16'($urandom);
                if (pick < 35) begin
                    send_req(OP_TICK, per, 1'($urandom), 4'($urandom));
                end else if (pick < 65) begin
                    send_req(OP_DISPATCH, per, 1'($urandom), 4'($urandom));
                end else if (pick < 92) begin
                    send_req(OP_COMPLETE, per, 1'($urandom), 4'($urandom));
                end else begin
                    // Favor short periods so slots come due within the run
                    spread = $urandom_range(0, 9);
                    if (spread < 7) begin
                        per = 16'($urandom_range(0, 12));
                    end else if (spread < 9) begin
                        per = 16'($urandom_range(0, 300));
                    end
                    send_req(OP_CREATE, per, ($urandom_range(0, 9) != 0), 4'($urandom));
                end
            end
            drain_responses();
        end

        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* periodic_task_dispatcher.f */
rtl/core/ptd_pkg.sv
rtl/core/ptd_if.sv
rtl/core/ptd_slot_mem.sv
rtl/core/ptd_due_unit.sv
rtl/core/ptd_core.sv
rtl/core/periodic_task_dispatcher.sv
test/ptd_checker.sv
test/tb_top.sv
